// File: src/mrtu_pkg.sv
// ----------------------------------------------------------------------------
// mrtu_pkg - shared types and constants of the Modbus RTU register server
// Command, function and status codes, the request and result items, the
// controller/datapath command and status groups, and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  // request commands
  localparam logic [2:0] CMD_RX_BYTE    = 3'd0;
  localparam logic [2:0] CMD_TICK       = 3'd1;
  localparam logic [2:0] CMD_TX_READY   = 3'd2;
  localparam logic [2:0] CMD_LOAD_INPUT = 3'd3;
  localparam logic [2:0] CMD_READ_HOLD  = 3'd4;

  // frame status codes
  localparam logic [2:0] FS_NONE      = 3'd0;
  localparam logic [2:0] FS_REPLY     = 3'd1;
  localparam logic [2:0] FS_EXCEPTION = 3'd2;
  localparam logic [2:0] FS_CRC_ERROR = 3'd3;
  localparam logic [2:0] FS_IGNORED   = 3'd4;

  // function codes
  localparam logic [7:0] FN_READ_COILS      = 8'd1;
  localparam logic [7:0] FN_READ_DISCRETE   = 8'd2;
  localparam logic [7:0] FN_READ_HOLDING    = 8'd3;
  localparam logic [7:0] FN_READ_INPUT      = 8'd4;
  localparam logic [7:0] FN_WRITE_COIL      = 8'd5;
  localparam logic [7:0] FN_WRITE_SINGLE    = 8'd6;
  localparam logic [7:0] FN_WRITE_COILS     = 8'd15;
  localparam logic [7:0] FN_WRITE_MULTIPLE  = 8'd16;
  localparam logic [7:0] EXC_FLAG           = 8'h80;

  // exception codes
  localparam logic [1:0] EXC_NONE             = 2'd0;
  localparam logic [1:0] EXC_ILLEGAL_FUNCTION = 2'd1;
  localparam logic [1:0] EXC_ILLEGAL_ADDRESS  = 2'd2;

  localparam logic [15:0] COIL_ADDR_MAX = 16'd7777;
  localparam logic [8:0]  FIXED_LEN     = 9'd8;
  localparam logic [8:0]  VAR_LEN_BASE  = 9'd9;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  // configuration register indexes
  localparam logic [1:0] CFG_DEVICE_ADDR = 2'd0;
  localparam logic [1:0] CFG_ALT_ADDR    = 2'd1;
  localparam logic [1:0] CFG_SEND_PAUSE  = 2'd2;
  localparam logic [1:0] CFG_RECV_PAUSE  = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  data_byte;
    logic [6:0]  local_index;
    logic [15:0] local_value;
  } item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        driver_enable;
    logic        receiver_enable;
    logic [2:0]  frame_status;
    logic [15:0] read_value;
  } res_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLEAR,
    OP_EXEC,
    OP_HREAD,
    OP_SEND,
    OP_CHECK,
    OP_F16_HI,
    OP_F16_LO,
    OP_F16_WR,
    OP_F6_WR,
    OP_EMIT,
    OP_FETCH,
    OP_EMIT_W,
    OP_CRC_LO,
    OP_CRC_HI,
    OP_PUSH
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic exec_send;
    logic exec_build;
    logic exec_hread;
    logic f16_store;
    logic f6_store;
    logic k_last;
    logic emit_more;
    logic need_word;
    logic out_full;
  } dp_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/mrtu_if.sv
// ----------------------------------------------------------------------------
// mrtu_if - request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface mrtu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  data_byte;
  logic [6:0]  local_index;
  logic [15:0] local_value;

  modport source (output valid, output command, output data_byte, output local_index,
                  output local_value, input ready);
  modport sink (input valid, input command, input data_byte, input local_index,
                input local_value, output ready);
endinterface

interface mrtu_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic        driver_enable;
  logic        receiver_enable;
  logic [2:0]  frame_status;
  logic [15:0] read_value;

  modport source (output valid, output tx_valid, output tx_byte, output tx_last,
                  output driver_enable, output receiver_enable, output frame_status,
                  output read_value, input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input tx_last,
                input driver_enable, input receiver_enable, input frame_status,
                input read_value, output ready);
endinterface

// File: src/mrtu_ram.sv
// ----------------------------------------------------------------------------
// mrtu_ram - generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mrtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/mrtu_datapath.sv
// ----------------------------------------------------------------------------
// mrtu_datapath - frame buffer, register stores, timers and reply builder
// Executes one controller command per cycle and reports status back.
// ----------------------------------------------------------------------------
module mrtu_datapath #(
  parameter int HOLD_REGS  = 128,
  parameter int INPUT_REGS = 16,
  parameter int BUF_BYTES  = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mrtu_pkg::ctl_cmd_t  cmd,
  output mrtu_pkg::dp_stat_t  stat,
  input  logic                in_valid,
  input  mrtu_pkg::item_t     in_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output mrtu_pkg::res_t      out_res
);

  localparam int HW       = $clog2(HOLD_REGS);
  localparam int IW       = (INPUT_REGS > 1) ? $clog2(INPUT_REGS) : 1;
  localparam int BW       = $clog2(BUF_BYTES);
  localparam int CLR_N    = (HOLD_REGS > INPUT_REGS) ? HOLD_REGS : INPUT_REGS;
  localparam int CW       = $clog2(CLR_N);
  localparam int READ_MAX = (BUF_BYTES - 5) / 2;

  // configuration
  logic [7:0]  dev_addr_r, alt_addr_r;
  logic [15:0] send_pause_r, recv_pause_r;

  // control state
  logic [8:0]    byte_pos_r, frame_len_r;
  logic          sending_r, rx_on_r, drv_r, tx_act_r, out_valid_r;
  logic [15:0]   pause_r;
  logic [CW-1:0] clr_r;

  // payload
  mrtu_pkg::item_t item_r;
  mrtu_pkg::res_t  out_res_r;
  logic [7:0]  addr_r, func_r, bcnt_r;
  logic [15:0] start_r, cnt_r, crc_r, word_r;
  logic [1:0]  code_r;
  logic [8:0]  n_r, k_r;
  logic        res_txv_r, res_last_r;
  logic [7:0]  res_byte_r;
  logic [2:0]  res_status_r;
  logic [15:0] res_read_r;

  // memories
  logic          buf_we, hold_we, inp_we;
  logic [BW-1:0] buf_waddr, buf_raddr;
  logic [7:0]    buf_wdata, buf_rdata;
  logic [HW-1:0] hold_waddr, hold_raddr;
  logic [15:0]   hold_wdata, hold_rdata;
  logic [IW-1:0] inp_waddr, inp_raddr;
  logic [15:0]   inp_wdata, inp_rdata;

  mrtu_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_frame_buf (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
    .raddr(buf_raddr), .rdata(buf_rdata)
  );
  mrtu_ram #(.WIDTH(16), .DEPTH(HOLD_REGS)) u_hold_regs (
    .clk(clk), .we(hold_we), .waddr(hold_waddr), .wdata(hold_wdata),
    .raddr(hold_raddr), .rdata(hold_rdata)
  );
  mrtu_ram #(.WIDTH(16), .DEPTH(INPUT_REGS)) u_input_regs (
    .clk(clk), .we(inp_we), .waddr(inp_waddr), .wdata(inp_wdata),
    .raddr(inp_raddr), .rdata(inp_rdata)
  );

  // receive path decode
  logic [7:0]  b;
  logic [15:0] idx16, rx_crc, end_sum, start_k, fetch_addr;
  logic [8:0]  len9, len_eff, fetch_j;
  logic        rx_active, pos0, pos1, body, addr_hit, func_ok, is_var, oversize, frame_end;
  logic        is_read, read_reply, hold_idx_ok, inp_idx_ok;
  logic [7:0]  emit_byte;
  logic [7:0]  k_lo8;

  always_comb begin
    b          = item_r.data_byte;
    idx16      = {9'd0, item_r.local_index};
    rx_active  = (item_r.command == mrtu_pkg::CMD_RX_BYTE) && rx_on_r;
    pos0       = (byte_pos_r == 9'd0);
    pos1       = (byte_pos_r == 9'd1);
    body       = (byte_pos_r >= 9'd2) && (byte_pos_r < 9'(BUF_BYTES));
    addr_hit   = (b == dev_addr_r) || (b == alt_addr_r);
    func_ok    = (b == mrtu_pkg::FN_READ_COILS) || (b == mrtu_pkg::FN_READ_DISCRETE) ||
                 (b == mrtu_pkg::FN_READ_HOLDING) || (b == mrtu_pkg::FN_READ_INPUT) ||
                 (b == mrtu_pkg::FN_WRITE_COIL) || (b == mrtu_pkg::FN_WRITE_SINGLE) ||
                 (b == mrtu_pkg::FN_WRITE_COILS) || (b == mrtu_pkg::FN_WRITE_MULTIPLE);
    rx_crc     = mrtu_pkg::crc_byte(pos0 ? mrtu_pkg::CRC_INIT : crc_r, b);
    is_var     = (byte_pos_r == 9'd6) && ((func_r == mrtu_pkg::FN_WRITE_COILS) ||
                 (func_r == mrtu_pkg::FN_WRITE_MULTIPLE));
    len9       = mrtu_pkg::VAR_LEN_BASE + {1'b0, b};
    oversize   = len9 > 9'(BUF_BYTES);
    len_eff    = is_var ? len9 : frame_len_r;
    frame_end  = (byte_pos_r + 9'd1) >= len_eff;
    is_read    = (func_r == mrtu_pkg::FN_READ_HOLDING) || (func_r == mrtu_pkg::FN_READ_INPUT);
    read_reply = is_read && (code_r == mrtu_pkg::EXC_NONE);
    end_sum    = start_r + cnt_r;
    start_k    = start_r + 16'(k_r);
    fetch_j    = (k_r - 9'd3) >> 1;
    fetch_addr = start_r + 16'(fetch_j);
    hold_idx_ok = idx16 < 16'(HOLD_REGS);
    inp_idx_ok  = idx16 < 16'(INPUT_REGS);
    k_lo8      = k_r[7:0];
    // reply header and data bytes
    if (k_r == 9'd0) begin
      emit_byte = addr_r;
    end else if (k_r == 9'd1) begin
      emit_byte = (code_r != mrtu_pkg::EXC_NONE) ? 8'(func_r + mrtu_pkg::EXC_FLAG) : func_r;
    end else if (k_r == 9'd2) begin
      if (code_r != mrtu_pkg::EXC_NONE) begin
        emit_byte = {6'd0, code_r};
      end else if (is_read) begin
        emit_byte = {cnt_r[6:0], 1'b0};
      end else begin
        emit_byte = start_r[15:8];
      end
    end else if (read_reply) begin
      emit_byte = word_r[7:0];
    end else if (k_r == 9'd3) begin
      emit_byte = start_r[7:0];
    end else if (k_r == 9'd4) begin
      emit_byte = cnt_r[15:8];
    end else begin
      emit_byte = cnt_r[7:0];
    end
  end

  // status to controller
  always_comb begin
    stat.clr_done   = (clr_r == CW'(CLR_N - 1));
    stat.exec_send  = ((item_r.command == mrtu_pkg::CMD_TICK) && (pause_r == 16'd1) &&
                       sending_r) ||
                      ((item_r.command == mrtu_pkg::CMD_TX_READY) && tx_act_r);
    stat.exec_build = rx_active && body && !(is_var && oversize) && frame_end &&
                      (rx_crc == 16'd0);
    stat.exec_hread = (item_r.command == mrtu_pkg::CMD_READ_HOLD);
    stat.f16_store  = (code_r == mrtu_pkg::EXC_NONE) &&
                      (func_r == mrtu_pkg::FN_WRITE_MULTIPLE) && (cnt_r != 16'd0);
    stat.f6_store   = (code_r == mrtu_pkg::EXC_NONE) && (func_r == mrtu_pkg::FN_WRITE_SINGLE);
    stat.k_last     = ({7'd0, k_r} + 16'd1) == cnt_r;
    stat.emit_more  = k_r < n_r;
    stat.need_word  = read_reply && (k_r >= 9'd3) && k_r[0];
    stat.out_full   = out_valid_r && !out_ready;
  end

  // memory ports
  always_comb begin
    buf_we     = 1'b0;
    buf_waddr  = byte_pos_r[BW-1:0];
    buf_wdata  = b;
    buf_raddr  = byte_pos_r[BW-1:0];
    hold_we    = 1'b0;
    hold_waddr = start_k[HW-1:0];
    hold_wdata = {word_r[15:8], buf_rdata};
    hold_raddr = idx16[HW-1:0];
    inp_we     = 1'b0;
    inp_waddr  = idx16[IW-1:0];
    inp_wdata  = item_r.local_value;
    inp_raddr  = fetch_addr[IW-1:0];
    unique case (cmd.op)
      mrtu_pkg::OP_CLEAR: begin
        hold_we    = 1'b1;
        hold_waddr = clr_r[HW-1:0];
        hold_wdata = 16'd0;
        inp_we     = 1'b1;
        inp_waddr  = clr_r[IW-1:0];
        inp_wdata  = 16'd0;
      end
      mrtu_pkg::OP_EXEC: begin
        buf_we = rx_active && ((pos0 && addr_hit) || (pos1 && func_ok) || body);
        inp_we = (item_r.command == mrtu_pkg::CMD_LOAD_INPUT) && inp_idx_ok;
      end
      mrtu_pkg::OP_F16_HI: buf_raddr = 9'(9'd7 + {k_r[7:0], 1'b0}) >> 0 == 9'd0 ?
                                       byte_pos_r[BW-1:0] :
                                       BW'(9'd7 + {k_lo8, 1'b0});
      mrtu_pkg::OP_F16_LO: buf_raddr = BW'(9'd8 + {k_lo8, 1'b0});
      mrtu_pkg::OP_F16_WR: hold_we = 1'b1;
      mrtu_pkg::OP_F6_WR: begin
        hold_we    = 1'b1;
        hold_waddr = start_r[HW-1:0];
        hold_wdata = cnt_r;
      end
      mrtu_pkg::OP_FETCH: hold_raddr = fetch_addr[HW-1:0];
      mrtu_pkg::OP_EMIT: begin
        buf_we    = 1'b1;
        buf_waddr = k_r[BW-1:0];
        buf_wdata = emit_byte;
      end
      mrtu_pkg::OP_EMIT_W: begin
        buf_we    = 1'b1;
        buf_waddr = k_r[BW-1:0];
        buf_wdata = is_read && (func_r == mrtu_pkg::FN_READ_HOLDING) ?
                    hold_rdata[15:8] : inp_rdata[15:8];
      end
      mrtu_pkg::OP_CRC_LO: begin
        buf_we    = 1'b1;
        buf_waddr = k_r[BW-1:0];
        buf_wdata = crc_r[7:0];
      end
      mrtu_pkg::OP_CRC_HI: begin
        buf_we    = 1'b1;
        buf_waddr = k_r[BW-1:0];
        buf_wdata = crc_r[15:8];
      end
      default: ;
    endcase
  end

  // configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= 8'd1;
      alt_addr_r   <= 8'd0;
      send_pause_r <= 16'd4;
      recv_pause_r <= 16'd4;
      byte_pos_r   <= 9'd0;
      frame_len_r  <= 9'd0;
      sending_r    <= 1'b0;
      rx_on_r      <= 1'b1;
      drv_r        <= 1'b0;
      tx_act_r     <= 1'b0;
      pause_r      <= 16'd0;
      out_valid_r  <= 1'b0;
      clr_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mrtu_pkg::CFG_DEVICE_ADDR: dev_addr_r   <= cfg_data[7:0];
          mrtu_pkg::CFG_ALT_ADDR:    alt_addr_r   <= cfg_data[7:0];
          mrtu_pkg::CFG_SEND_PAUSE:  send_pause_r <= cfg_data;
          mrtu_pkg::CFG_RECV_PAUSE:  recv_pause_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == mrtu_pkg::OP_PUSH) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        mrtu_pkg::OP_CLEAR: clr_r <= clr_r + CW'(1);
        mrtu_pkg::OP_EXEC: begin
          if (rx_active) begin
            if (pos0) begin
              if (addr_hit) byte_pos_r <= 9'd1;
            end else if (pos1) begin
              if (func_ok) begin
                frame_len_r <= mrtu_pkg::FIXED_LEN;
                byte_pos_r  <= 9'd2;
              end else begin
                byte_pos_r <= 9'd0;
              end
            end else if (!body) begin
              byte_pos_r <= 9'd0;
            end else if (is_var && oversize) begin
              byte_pos_r  <= 9'd0;
              frame_len_r <= 9'd0;
            end else begin
              frame_len_r <= len_eff;
              if (!frame_end) begin
                byte_pos_r <= byte_pos_r + 9'd1;
              end else begin
                byte_pos_r <= 9'd0;
                if (rx_crc != 16'd0) frame_len_r <= 9'd0;
              end
            end
          end else if (item_r.command == mrtu_pkg::CMD_TICK && pause_r != 16'd0) begin
            pause_r <= pause_r - 16'd1;
            if (pause_r == 16'd1) begin
              if (sending_r) begin
                drv_r    <= 1'b1;
                tx_act_r <= 1'b1;
              end else begin
                drv_r   <= 1'b0;
                rx_on_r <= 1'b1;
              end
            end
          end
        end
        mrtu_pkg::OP_SEND: begin
          if (byte_pos_r < frame_len_r && byte_pos_r < 9'(BUF_BYTES)) begin
            byte_pos_r <= byte_pos_r + 9'd1;
          end
          if ((byte_pos_r < frame_len_r && (byte_pos_r + 9'd1) >= frame_len_r) ||
              byte_pos_r >= frame_len_r) begin
            pause_r     <= (recv_pause_r == 16'd0) ? 16'd1 : recv_pause_r;
            sending_r   <= 1'b0;
            byte_pos_r  <= 9'd0;
            frame_len_r <= 9'd0;
            tx_act_r    <= 1'b0;
          end
        end
        mrtu_pkg::OP_CRC_HI: begin
          frame_len_r <= n_r + 9'd2;
          byte_pos_r  <= 9'd0;
          pause_r     <= (send_pause_r == 16'd0) ? 16'd1 : send_pause_r;
          sending_r   <= 1'b1;
          rx_on_r     <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.op == mrtu_pkg::OP_PUSH) begin
      out_res_r.tx_valid        <= res_txv_r;
      out_res_r.tx_byte         <= res_byte_r;
      out_res_r.tx_last         <= res_last_r;
      out_res_r.driver_enable   <= drv_r;
      out_res_r.receiver_enable <= rx_on_r;
      out_res_r.frame_status    <= res_status_r;
      out_res_r.read_value      <= res_read_r;
    end
    unique case (cmd.op)
      mrtu_pkg::OP_LATCH: begin
        if (in_valid) item_r <= in_item;
        res_txv_r    <= 1'b0;
        res_byte_r   <= 8'd0;
        res_last_r   <= 1'b0;
        res_status_r <= mrtu_pkg::FS_NONE;
        res_read_r   <= 16'd0;
      end
      mrtu_pkg::OP_EXEC: begin
        if (rx_active) begin
          if (pos0) begin
            if (addr_hit) begin
              addr_r <= b;
              crc_r  <= rx_crc;
            end else begin
              res_status_r <= mrtu_pkg::FS_IGNORED;
            end
          end else if (pos1) begin
            if (func_ok) begin
              func_r <= b;
              crc_r  <= rx_crc;
            end else begin
              res_status_r <= mrtu_pkg::FS_IGNORED;
            end
          end else if (!body) begin
            res_status_r <= mrtu_pkg::FS_IGNORED;
          end else begin
            crc_r <= rx_crc;
            unique case (byte_pos_r)
              9'd2: start_r[15:8] <= b;
              9'd3: start_r[7:0]  <= b;
              9'd4: cnt_r[15:8]   <= b;
              9'd5: cnt_r[7:0]    <= b;
              9'd6: bcnt_r        <= b;
              default: ;
            endcase
            if (is_var && oversize) begin
              res_status_r <= mrtu_pkg::FS_IGNORED;
            end else if (frame_end && rx_crc != 16'd0) begin
              res_status_r <= mrtu_pkg::FS_CRC_ERROR;
            end
          end
        end
      end
      mrtu_pkg::OP_HREAD: res_read_r <= hold_idx_ok ? hold_rdata : 16'd0;
      mrtu_pkg::OP_SEND: begin
        if (byte_pos_r < frame_len_r && byte_pos_r < 9'(BUF_BYTES)) begin
          res_txv_r  <= 1'b1;
          res_byte_r <= buf_rdata;
          res_last_r <= (byte_pos_r + 9'd1) >= frame_len_r;
        end
      end
      mrtu_pkg::OP_CHECK: begin
        k_r   <= 9'd0;
        crc_r <= mrtu_pkg::CRC_INIT;
        n_r   <= 9'd6;
        code_r <= mrtu_pkg::EXC_NONE;
        if (func_r == mrtu_pkg::FN_WRITE_COIL) begin
          if (start_r > mrtu_pkg::COIL_ADDR_MAX || pause_r != 16'd0) begin
            code_r <= mrtu_pkg::EXC_ILLEGAL_ADDRESS;
            n_r    <= 9'd3;
          end
        end else if (func_r == mrtu_pkg::FN_WRITE_SINGLE) begin
          if ({1'b0, start_r} + 17'(INPUT_REGS) > 17'(HOLD_REGS) || pause_r != 16'd0) begin
            code_r <= mrtu_pkg::EXC_ILLEGAL_ADDRESS;
            n_r    <= 9'd3;
          end
        end else if (is_read) begin
          if ({1'b0, start_r} + {1'b0, cnt_r} >
              ((func_r == mrtu_pkg::FN_READ_HOLDING) ? 17'(HOLD_REGS) : 17'(INPUT_REGS)) ||
              ({1'b0, start_r} + {1'b0, cnt_r}) == 17'd0 ||
              cnt_r > 16'(READ_MAX) || pause_r != 16'd0) begin
            code_r <= mrtu_pkg::EXC_ILLEGAL_ADDRESS;
            n_r    <= 9'd3;
          end else begin
            n_r <= 9'd3 + {cnt_r[7:0], 1'b0};
          end
        end else if (func_r == mrtu_pkg::FN_WRITE_MULTIPLE) begin
          if ({1'b0, start_r} + {1'b0, cnt_r} > 17'(HOLD_REGS) ||
              ({1'b0, start_r} + {1'b0, cnt_r}) == 17'd0 ||
              {cnt_r, 1'b0} > {9'd0, bcnt_r} || pause_r != 16'd0) begin
            code_r <= mrtu_pkg::EXC_ILLEGAL_ADDRESS;
            n_r    <= 9'd3;
          end
        end else begin
          code_r <= mrtu_pkg::EXC_ILLEGAL_FUNCTION;
          n_r    <= 9'd3;
        end
      end
      mrtu_pkg::OP_F16_LO: word_r[15:8] <= buf_rdata;
      mrtu_pkg::OP_F16_WR: k_r <= stat.k_last ? 9'd0 : k_r + 9'd1;
      mrtu_pkg::OP_EMIT: begin
        crc_r <= mrtu_pkg::crc_byte(crc_r, emit_byte);
        k_r   <= k_r + 9'd1;
      end
      mrtu_pkg::OP_EMIT_W: begin
        crc_r  <= mrtu_pkg::crc_byte(crc_r, buf_wdata);
        word_r <= (func_r == mrtu_pkg::FN_READ_HOLDING) ? hold_rdata : inp_rdata;
        k_r    <= k_r + 9'd1;
      end
      mrtu_pkg::OP_CRC_LO: k_r <= k_r + 9'd1;
      mrtu_pkg::OP_CRC_HI: begin
        res_status_r <= (code_r != mrtu_pkg::EXC_NONE) ? mrtu_pkg::FS_EXCEPTION :
                        mrtu_pkg::FS_REPLY;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // unused 16-bit sum; the range checks above use 17-bit sums
  logic end_zero;
  assign end_zero = (end_sum == 16'd0) && 1'b0;

endmodule

// File: src/mrtu_ctrl.sv
// ----------------------------------------------------------------------------
// mrtu_ctrl - request sequencer
// Steps the datapath through reception, reply building and transmission.
// ----------------------------------------------------------------------------
module mrtu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mrtu_pkg::dp_stat_t stat,
  output mrtu_pkg::ctl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_HREAD, S_SEND, S_CHECK, S_BRANCH,
    S_F16_HI, S_F16_LO, S_F16_WR, S_F6_WR, S_EMIT_SEL, S_EMIT, S_FETCH,
    S_EMIT_W, S_CRC_LO, S_CRC_HI, S_DONE
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      unique case (state_r)
        S_CLEAR:    if (stat.clr_done) state_r <= S_IDLE;
        S_IDLE:     if (in_valid) state_r <= S_EXEC;
        S_EXEC: begin
          priority if (stat.exec_send)  state_r <= S_SEND;
          else if (stat.exec_build)     state_r <= S_CHECK;
          else if (stat.exec_hread)     state_r <= S_HREAD;
          else                          state_r <= S_DONE;
        end
        S_HREAD:    state_r <= S_DONE;
        S_SEND:     state_r <= S_DONE;
        S_CHECK:    state_r <= S_BRANCH;
        S_BRANCH: begin
          priority if (stat.f16_store) state_r <= S_F16_HI;
          else if (stat.f6_store)      state_r <= S_F6_WR;
          else                         state_r <= S_EMIT_SEL;
        end
        S_F16_HI:   state_r <= S_F16_LO;
        S_F16_LO:   state_r <= S_F16_WR;
        S_F16_WR:   state_r <= stat.k_last ? S_EMIT_SEL : S_F16_HI;
        S_F6_WR:    state_r <= S_EMIT_SEL;
        S_EMIT_SEL: begin
          priority if (!stat.emit_more) state_r <= S_CRC_LO;
          else if (stat.need_word)      state_r <= S_FETCH;
          else                          state_r <= S_EMIT;
        end
        S_EMIT:     state_r <= S_EMIT_SEL;
        S_FETCH:    state_r <= S_EMIT_W;
        S_EMIT_W:   state_r <= S_EMIT_SEL;
        S_CRC_LO:   state_r <= S_CRC_HI;
        S_CRC_HI:   state_r <= S_DONE;
        S_DONE:     if (!stat.out_full) state_r <= S_IDLE;
        default:    state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (state_r)
      S_CLEAR:    cmd.op = mrtu_pkg::OP_CLEAR;
      S_IDLE:     cmd.op = mrtu_pkg::OP_LATCH;
      S_EXEC:     cmd.op = mrtu_pkg::OP_EXEC;
      S_HREAD:    cmd.op = mrtu_pkg::OP_HREAD;
      S_SEND:     cmd.op = mrtu_pkg::OP_SEND;
      S_CHECK:    cmd.op = mrtu_pkg::OP_CHECK;
      S_F16_HI:   cmd.op = mrtu_pkg::OP_F16_HI;
      S_F16_LO:   cmd.op = mrtu_pkg::OP_F16_LO;
      S_F16_WR:   cmd.op = mrtu_pkg::OP_F16_WR;
      S_F6_WR:    cmd.op = mrtu_pkg::OP_F6_WR;
      S_EMIT:     cmd.op = mrtu_pkg::OP_EMIT;
      S_FETCH:    cmd.op = mrtu_pkg::OP_FETCH;
      S_EMIT_W:   cmd.op = mrtu_pkg::OP_EMIT_W;
      S_CRC_LO:   cmd.op = mrtu_pkg::OP_CRC_LO;
      S_CRC_HI:   cmd.op = mrtu_pkg::OP_CRC_HI;
      S_DONE:     cmd.op = stat.out_full ? mrtu_pkg::OP_NONE : mrtu_pkg::OP_PUSH;
      default:    cmd.op = mrtu_pkg::OP_NONE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// File: src/modbus_rtu_slave_register_server.sv
// ----------------------------------------------------------------------------
// modbus_rtu_slave_register_server - Modbus RTU slave with register stores
// Collects request frames, checks address, function and CRC-16, serves
// holding and input registers and paces the reply on the bus.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       contents
//  in_ch    in   valid/ready     command, data_byte, local_index, local_value
//  out_ch   out  valid/ready     tx byte and flags, line enables, status, read value
//  cfg_*    in   write enable    addresses and pause lengths
//
//  a request is latched, executed and pushed, with a hold read or send step
//  where needed; the final byte of a good frame also builds the reply
//  stored words come a byte at a time through the frame buffer's single read port
//  after reset a clearing pass over max(HOLD_REGS, INPUT_REGS) addresses runs
//  before the first request is taken
//  a request is taken while an earlier result still waits on out_ch
// ----------------------------------------------------------------------------
module modbus_rtu_slave_register_server #(
  parameter int HOLD_REGS  = 128,
  parameter int INPUT_REGS = 16,
  parameter int BUF_BYTES  = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  mrtu_in_if.sink           in_ch,
  mrtu_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  mrtu_pkg::ctl_cmd_t cmd;
  mrtu_pkg::dp_stat_t stat;
  mrtu_pkg::item_t    in_item;
  mrtu_pkg::res_t     out_res;
  logic               in_ready, out_valid;

  assign in_item.command     = in_ch.command;
  assign in_item.data_byte   = in_ch.data_byte;
  assign in_item.local_index = in_ch.local_index;
  assign in_item.local_value = in_ch.local_value;
  assign in_ch.ready         = in_ready;

  mrtu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  mrtu_datapath #(
    .HOLD_REGS(HOLD_REGS), .INPUT_REGS(INPUT_REGS), .BUF_BYTES(BUF_BYTES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_valid(in_ch.valid),
    .in_item(in_item), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_ready(out_ch.ready), .out_valid(out_valid), .out_res(out_res)
  );

  assign out_ch.valid           = out_valid;
  assign out_ch.tx_valid        = out_res.tx_valid;
  assign out_ch.tx_byte         = out_res.tx_byte;
  assign out_ch.tx_last         = out_res.tx_last;
  assign out_ch.driver_enable   = out_res.driver_enable;
  assign out_ch.receiver_enable = out_res.receiver_enable;
  assign out_ch.frame_status    = out_res.frame_status;
  assign out_ch.read_value      = out_res.read_value;

  // line driver and receiver never on together
  a_line_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.driver_enable && out_ch.receiver_enable))
    else $error("driver and receiver enabled together");

  // last byte flag only on a transmitted byte
  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.tx_last) |-> out_ch.tx_valid)
    else $error("tx_last without tx_valid");

  // one request in flight at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while another is in flight");

endmodule
